// ===== design/pcapd_pkg.sv =====
// Shared types, constants and byte-order helpers of the PCAP stream deframer.
package pcapd_pkg;

    // Magic numbers as read in little-endian order from the first four bytes.
    localparam logic [31:0] MAGIC_US     = 32'hA1B2C3D4;
    localparam logic [31:0] MAGIC_NS     = 32'hA1B23C4D;
    localparam logic [31:0] MAGIC_US_REV = 32'hD4C3B2A1;
    localparam logic [31:0] MAGIC_NS_REV = 32'h4D3CB2A1;
    localparam logic [31:0] MAGIC_PCAPNG = 32'h0A0D0D0A;

    // Header geometry.
    localparam int unsigned HDR_BYTES     = 24;
    localparam int unsigned IDX_W         = $clog2(HDR_BYTES);
    localparam logic [IDX_W-1:0] FILE_HDR_LAST = IDX_W'(HDR_BYTES - 1);
    localparam logic [IDX_W-1:0] PKT_HDR_LAST  = IDX_W'(15);

    // Timestamp scaling.
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [9:0]  NS_PER_US  = 10'd1000;
    localparam int unsigned SEC_NS_W   = 62;
    localparam int unsigned FRAC_NS_W  = 42;

    // Link type keeps the low 16 bits only.
    localparam logic [31:0] LINK_MASK = 32'h0000FFFF;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_FILE_HDR = 2'd0,
        KIND_PKT_HDR  = 2'd1,
        KIND_PAYLOAD  = 2'd2,
        KIND_ERROR    = 2'd3
    } t_kind;

    // Error codes.
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_MAGIC = 3'd1,
        ERR_PCAPNG    = 3'd2,
        ERR_SHORT_HDR = 3'd3,
        ERR_TRUNCATED = 3'd4
    } t_err;

    // One input request.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    // One result request.
    typedef struct packed {
        t_kind        kind;
        logic [31:0]  magic_value;
        logic [15:0]  ver_major;
        logic [15:0]  ver_minor;
        logic [31:0]  snap_length;
        logic [15:0]  link_type;
        logic [63:0]  timestamp_ns;
        logic [31:0]  captured_length;
        logic [31:0]  original_length;
        logic [7:0]   payload_byte;
        logic         last_byte;
        t_err         error_code;
    } t_out_item;

    // Assemble a 32-bit word from four consecutive stream bytes.
    function automatic logic [31:0] rd32(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic sw);
        return sw ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

    // Assemble a 16-bit word from two consecutive stream bytes.
    function automatic logic [15:0] rd16(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic sw);
        return sw ? {b0, b1} : {b1, b0};
    endfunction

endpackage

// ===== design/pcap_stream_deframer.sv =====
// Top level of the PCAP stream deframer: header parsing, payload framing and result output.
//
// The deframer takes one capture byte per clock cycle while o_in_ready is high and gives
// at most one result per byte: a file header report (when enabled), a packet header, a
// payload byte or an error. The result for an accepted byte goes to the result register,
// or to a one-entry skid stage while the output is stalled; the skid lets input continue
// for one more result-bearing byte, and o_in_ready drops only while that entry is occupied.
// The packet timestamp is scaled by registered multipliers that work on the stored seconds
// and fraction while the rest of the packet header streams in, so the final step is one
// 64-bit add. After an error or an end of stream the block drops all further input without
// results until reset.
module pcap_stream_deframer
    import pcapd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_emit_file_headers,
    output logic      o_cfg_ready,
    input  logic      i_in_valid,
    input  t_in_item  i_in,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_ready
);

    typedef enum logic [1:0] {
        PH_FILE,
        PH_PKT,
        PH_NEWFILE,
        PH_PAYLOAD
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [IDX_W-1:0]    r_byte_index, n_byte_index;
    logic                r_swap, n_swap;
    logic                r_nano, n_nano;
    logic [15:0]         r_link, n_link;
    logic [31:0]         r_remaining, n_remaining;
    logic                r_halted, n_halted;
    logic                r_emit;
    logic [7:0]          r_store [HDR_BYTES];

    logic [7:0]          view [HDR_BYTES];
    logic                in_acc;
    logic                push_ready;
    logic                res_valid;
    t_out_item           res;
    logic                store_we;
    logic                do_take;
    logic                take_sw;
    logic [31:0]         raw_magic;
    logic [31:0]         take_magic;
    logic [15:0]         take_link;
    logic [31:0]         cap_len;
    logic [SEC_NS_W-1:0]  sec_ns;
    logic [FRAC_NS_W-1:0] frac_ns;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = push_ready;
    assign in_acc      = i_in_valid && push_ready;

    // Header bytes with the byte now arriving merged in at its slot.
    always_comb begin
        for (int k = 0; k < HDR_BYTES; k++) begin
            view[k] = (r_byte_index == IDX_W'(k)) ? i_in.data_byte : r_store[k];
        end
    end

    assign raw_magic  = rd32(view[0], view[1], view[2], view[3], 1'b0);
    assign take_magic = rd32(view[0], view[1], view[2], view[3], take_sw);
    assign take_link  = 16'(rd32(view[20], view[21], view[22], view[23], take_sw) & LINK_MASK);
    assign cap_len    = rd32(view[8], view[9], view[10], view[11], r_swap);

    // Timestamp products from the stored seconds and fraction.
    pcapd_ts_mult u_ts_mult (
        .i_clk     (i_clk),
        .i_secs    (rd32(r_store[0], r_store[1], r_store[2], r_store[3], r_swap)),
        .i_frac    (rd32(r_store[4], r_store[5], r_store[6], r_store[7], r_swap)),
        .i_nano    (r_nano),
        .o_sec_ns  (sec_ns),
        .o_frac_ns (frac_ns)
    );

    // Parser: next state and the result for the accepted byte.
    always_comb begin
        n_phase      = r_phase;
        n_byte_index = r_byte_index;
        n_swap       = r_swap;
        n_nano       = r_nano;
        n_link       = r_link;
        n_remaining  = r_remaining;
        n_halted     = r_halted;
        res_valid    = 1'b0;
        res          = '0;
        store_we     = 1'b0;
        do_take      = 1'b0;
        take_sw      = 1'b0;

        if (in_acc && !r_halted) begin
            if (i_in.end_of_stream) begin
                n_halted = 1'b1;
                if (r_phase == PH_PAYLOAD && r_remaining != '0) begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TRUNCATED;
                end else if (!(r_phase == PH_PKT && r_byte_index == '0)) begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_SHORT_HDR;
                end
            end else if (r_phase == PH_PAYLOAD) begin
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = i_in.data_byte;
                res.last_byte    = (r_remaining == 32'd1);
                if (r_remaining <= 32'd1) begin
                    n_remaining  = '0;
                    n_phase      = PH_PKT;
                    n_byte_index = '0;
                end else begin
                    n_remaining = r_remaining - 32'd1;
                end
            end else begin
                store_we     = 1'b1;
                n_byte_index = r_byte_index + IDX_W'(1);
                case (r_phase)
                    PH_FILE: begin
                        if (r_byte_index == FILE_HDR_LAST) begin
                            if (raw_magic == MAGIC_PCAPNG) begin
                                n_halted       = 1'b1;
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_PCAPNG;
                            end else if (raw_magic == MAGIC_US || raw_magic == MAGIC_NS) begin
                                do_take = 1'b1;
                            end else if (raw_magic == MAGIC_US_REV ||
                                         raw_magic == MAGIC_NS_REV) begin
                                do_take = 1'b1;
                                take_sw = 1'b1;
                            end else begin
                                n_halted       = 1'b1;
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_BAD_MAGIC;
                            end
                        end
                    end
                    PH_NEWFILE: begin
                        if (r_byte_index == FILE_HDR_LAST) begin
                            do_take = 1'b1;
                            take_sw = (raw_magic == MAGIC_US_REV ||
                                       raw_magic == MAGIC_NS_REV);
                        end
                    end
                    PH_PKT: begin
                        if (r_byte_index == PKT_HDR_LAST) begin
                            if (raw_magic == MAGIC_US || raw_magic == MAGIC_NS ||
                                raw_magic == MAGIC_US_REV || raw_magic == MAGIC_NS_REV) begin
                                // A magic in place of a packet header opens a new trace.
                                n_phase = PH_NEWFILE;
                            end else begin
                                res_valid           = 1'b1;
                                res.kind            = KIND_PKT_HDR;
                                res.link_type       = r_link;
                                res.timestamp_ns    = 64'(sec_ns) + 64'(frac_ns);
                                res.captured_length = cap_len;
                                res.original_length = rd32(view[12], view[13], view[14],
                                                           view[15], r_swap);
                                n_byte_index        = '0;
                                n_remaining         = cap_len;
                                n_phase             = (cap_len != '0) ? PH_PAYLOAD : PH_PKT;
                            end
                        end
                    end
                    default: begin
                    end
                endcase

                // Accept a complete file header: byte order, timestamp mode, link type.
                if (do_take) begin
                    n_swap       = take_sw;
                    n_nano       = (take_magic == MAGIC_NS);
                    n_link       = take_link;
                    n_phase      = PH_PKT;
                    n_byte_index = '0;
                    if (r_emit) begin
                        res_valid       = 1'b1;
                        res.kind        = KIND_FILE_HDR;
                        res.magic_value = take_magic;
                        res.ver_major   = rd16(view[4], view[5], take_sw);
                        res.ver_minor   = rd16(view[6], view[7], take_sw);
                        res.snap_length = rd32(view[16], view[17], view[18], view[19],
                                               take_sw);
                        res.link_type   = take_link;
                    end
                end
            end
        end
    end

    // Parser state and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FILE;
            r_byte_index <= '0;
            r_swap       <= 1'b0;
            r_nano       <= 1'b0;
            r_link       <= '0;
            r_remaining  <= '0;
            r_halted     <= 1'b0;
            r_emit       <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
            r_swap       <= n_swap;
            r_nano       <= n_nano;
            r_link       <= n_link;
            r_remaining  <= n_remaining;
            r_halted     <= n_halted;
            if (i_cfg_valid) begin
                r_emit <= i_cfg_emit_file_headers;
            end
        end
    end

    // Header byte store.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_byte_index] <= i_in.data_byte;
        end
    end

    // Result register and skid stage.
    pcapd_out_skid u_out_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (res_valid),
        .i_push       (res),
        .o_push_ready (push_ready),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out),
        .i_out_ready  (i_out_ready)
    );

endmodule

// ===== design/pcapd_ts_mult.sv =====
// Timestamp scaling: seconds and fraction of the stored packet header to nanoseconds.
module pcapd_ts_mult
    import pcapd_pkg::*;
(
    input  logic                 i_clk,
    input  logic [31:0]          i_secs,
    input  logic [31:0]          i_frac,
    input  logic                 i_nano,
    output logic [SEC_NS_W-1:0]  o_sec_ns,
    output logic [FRAC_NS_W-1:0] o_frac_ns
);

    logic [SEC_NS_W-1:0]  r_sec_ns;
    logic [FRAC_NS_W-1:0] r_frac_ns;
    logic [SEC_NS_W-1:0]  n_sec_ns;
    logic [FRAC_NS_W-1:0] n_frac_ns;

    // Products follow the stored header bytes; they settle long before
    // the last header byte arrives.
    always_comb begin
        n_sec_ns  = SEC_NS_W'(i_secs) * SEC_NS_W'(NS_PER_SEC);
        n_frac_ns = i_nano ? FRAC_NS_W'(i_frac)
                           : FRAC_NS_W'(i_frac) * FRAC_NS_W'(NS_PER_US);
    end

    always_ff @(posedge i_clk) begin
        r_sec_ns  <= n_sec_ns;
        r_frac_ns <= n_frac_ns;
    end

    assign o_sec_ns  = r_sec_ns;
    assign o_frac_ns = r_frac_ns;

endmodule

// ===== design/pcapd_out_skid.sv =====
// Result register with a skid stage, decoupling the input side from the output stall.
module pcapd_out_skid
    import pcapd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push_valid,
    input  t_out_item i_push,
    output logic      o_push_ready,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_ready
);

    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;

    assign o_push_ready = !r_skid_valid;

    // Control: the output register refills from the skid first, then from a new request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || i_out_ready) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_push_valid;
                end
            end else if (i_push_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push_valid) begin
                r_out <= i_push;
            end
        end else if (i_push_valid) begin
            r_skid <= i_push;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
